@@ design/wdt_pkg.sv @@
// Shared types and constants for the watchdog timer peripheral.
// No dependencies; used by wdt_core and watchdog_timer_peripheral.
package wdt_pkg;

  // Command codes carried by each input beat
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Register byte offsets
  localparam logic [11:0] OFS_LOAD    = 12'h000;
  localparam logic [11:0] OFS_VALUE   = 12'h004;
  localparam logic [11:0] OFS_CONTROL = 12'h008;
  localparam logic [11:0] OFS_INTCLR  = 12'h00C;
  localparam logic [11:0] OFS_RIS     = 12'h010;
  localparam logic [11:0] OFS_MIS     = 12'h014;
  localparam logic [11:0] OFS_LOCK    = 12'hC00;

  // Lock key and control bit positions
  localparam logic [31:0] UNLOCK_KEY = 32'h1ACC_E551;
  localparam int CTL_INTEN_BIT = 0;
  localparam int CTL_RESEN_BIT = 1;

  // One input beat
  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] reg_offset;
    logic [31:0] write_data;
  } wdt_item_t;

  // One result beat
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
    logic        reset_out;
  } wdt_result_t;

endpackage

@@ design/wdt_core.sv @@
// Watchdog register file, down counter and result logic for one beat.
// Depends on wdt_pkg for item and result types and register decode.
module wdt_core #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  wdt_pkg::wdt_item_t   item,
  output wdt_pkg::wdt_result_t result
);
  import wdt_pkg::*;

  logic [COUNTER_WIDTH-1:0] reload_value, reload_value_next;
  logic [COUNTER_WIDTH-1:0] down_counter, down_counter_next;
  logic irq_enable, irq_enable_next;
  logic reset_enable, reset_enable_next;
  logic irq_pending, irq_pending_next;
  logic write_locked, write_locked_next;
  logic reset_latched, reset_latched_next;
  logic [31:0] rd;
  logic new_en;

  // Compute next state and read data for the current beat
  always_comb begin
    reload_value_next  = reload_value;
    down_counter_next  = down_counter;
    irq_enable_next    = irq_enable;
    reset_enable_next  = reset_enable;
    irq_pending_next   = irq_pending;
    write_locked_next  = write_locked;
    reset_latched_next = reset_latched;
    rd     = '0;
    new_en = item.write_data[CTL_INTEN_BIT];
    case (item.command)
      CMD_TICK: begin
        // Advance only while enabled and not yet latched into reset
        if (!reset_latched && irq_enable) begin
          if (down_counter == '0) begin
            if (irq_pending && reset_enable) reset_latched_next = 1'b1;
            irq_pending_next  = 1'b1;
            down_counter_next = reload_value;
          end else begin
            down_counter_next = down_counter - COUNTER_WIDTH'(1);
          end
        end
      end
      CMD_READ: begin
        case (item.reg_offset)
          OFS_LOAD:    rd = 32'(reload_value);
          OFS_VALUE:   rd = 32'(down_counter);
          OFS_CONTROL: rd = {30'b0, reset_enable, irq_enable};
          OFS_RIS:     rd = 32'(irq_pending);
          OFS_MIS:     rd = 32'(irq_pending & irq_enable);
          OFS_LOCK:    rd = 32'(write_locked);
          default:     rd = '0;
        endcase
      end
      CMD_WRITE: begin
        if (item.reg_offset == OFS_LOCK) begin
          write_locked_next = (item.write_data != UNLOCK_KEY);
        end else if (!write_locked) begin
          case (item.reg_offset)
            OFS_LOAD: begin
              reload_value_next = item.write_data[COUNTER_WIDTH-1:0];
              down_counter_next = item.write_data[COUNTER_WIDTH-1:0];
            end
            OFS_CONTROL: begin
              // Reload on a rising interrupt enable
              if (new_en && !irq_enable) down_counter_next = reload_value;
              irq_enable_next   = new_en;
              reset_enable_next = item.write_data[CTL_RESEN_BIT];
            end
            OFS_INTCLR: begin
              irq_pending_next  = 1'b0;
              down_counter_next = reload_value;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    result.read_data = rd;
    result.irq_out   = irq_pending_next & irq_enable_next;
    result.reset_out = reset_latched_next;
  end

  // Commit the beat's effect on state
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value  <= '1;
      down_counter  <= '1;
      irq_enable    <= 1'b0;
      reset_enable  <= 1'b0;
      irq_pending   <= 1'b0;
      write_locked  <= 1'b0;
      reset_latched <= 1'b0;
    end else if (step) begin
      reload_value  <= reload_value_next;
      down_counter  <= down_counter_next;
      irq_enable    <= irq_enable_next;
      reset_enable  <= reset_enable_next;
      irq_pending   <= irq_pending_next;
      write_locked  <= write_locked_next;
      reset_latched <= reset_latched_next;
    end
  end

endmodule

@@ design/watchdog_timer_peripheral.sv @@
// Watchdog timer peripheral top level: input register, wdt_core, result register.
// Depends on wdt_pkg and wdt_core.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------
//   in      | in_valid/in_stall  | command, reg_offset, write_data
//   out     | out_valid/out_stall| read_data, irq_out, reset_out
//
// One beat per cycle sustained while out_stall is low; each result passes the
// input register, then the result register, with the core's decrement,
// compare and read mux combinational between them.
// Sync active-high rst clears valid bits and flags; sets LOAD/VALUE to all ones.
// A stalled result holds in the output register while one more beat waits in
// the input register; in_stall rises only when both are full.
module watchdog_timer_peripheral #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [11:0] reg_offset,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        irq_out,
  output logic        reset_out
);
  import wdt_pkg::*;

  logic        s1_valid;
  wdt_item_t   s1_item;
  wdt_result_t core_result;
  logic        out_ready;
  logic        s1_ready;
  logic        step;

  // Stage enables
  assign out_ready = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign step      = s1_valid && out_ready;
  assign in_stall  = !s1_ready;

  // Input register: capture a beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_item.command    <= command;
      s1_item.reg_offset <= reg_offset;
      s1_item.write_data <= write_data;
    end
  end

  wdt_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .result (core_result)
  );

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      read_data <= core_result.read_data;
      irq_out   <= core_result.irq_out;
      reset_out <= core_result.reset_out;
    end
  end

endmodule
